// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/wmdr_pkg.sv -----
// Shared types and constants for the windowed mean deadband reporter.
package wmdr_pkg;

  localparam int SUM_W     = 48;
  localparam int VAL_W     = 32;
  localparam int TS_W      = 32;
  localparam int OUT_CNT_W = 16;
  localparam int DB_W      = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = $clog2(SUM_W);
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_DEADBAND = 1'd1;

  localparam logic [TS_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [DB_W-1:0] DEADBAND_RESET = 31'd0;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] MEAN_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MEAN_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIX,
    BK_CMP,
    BK_OUT
  } back_state_t;

endpackage

// ----- sv/windowed_mean_deadband_reporter.sv -----
// Top level of the windowed mean deadband reporter.
// Input side takes one item per cycle while the window queue has room.
// A closing item's result goes through the queue, the 48-step serial divider and the deadband check.
// The back end takes a new closed window only once the last one is done, output wait included.
// Synchronous active-high reset clears the window, queue and last report.
`include "assert_macros.svh"

module windowed_mean_deadband_reporter #(
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [63:0]                        s_tdata,   // sample_value, timestamp_ms
  input  logic                               s_tuser,   // sample_finite
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,   // mean_value, samples_averaged
  input  logic                               cfg_we,
  input  logic [wmdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmdr_pkg::CFG_W-1:0]         cfg_data
);

  localparam int ENTRY_W = wmdr_pkg::SUM_W + COUNT_BITS;

  logic [wmdr_pkg::TS_W-1:0] window_interval_ms;
  logic [wmdr_pkg::DB_W-1:0] report_deadband;

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop;
  logic               q_valid;
  logic               q_full;
  logic [ENTRY_W-1:0] q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_interval_ms <= wmdr_pkg::INTERVAL_RESET;
      report_deadband    <= wmdr_pkg::DEADBAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmdr_pkg::REG_WINDOW_INTERVAL: window_interval_ms <= cfg_data;
        wmdr_pkg::REG_REPORT_DEADBAND: report_deadband <= cfg_data[wmdr_pkg::DB_W-1:0];
        default: window_interval_ms <= window_interval_ms;
      endcase
    end
  end

  wmdr_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .interval  (window_interval_ms),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  wmdr_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .full      (q_full),
    .head      (q_head)
  );

  wmdr_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .deadband (report_deadband),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `ASSERT_IMPLIES(a_no_overflow, q_push, !q_full, "window pushed into full queue")
  `ASSERT_IMPLIES(a_no_underflow, q_pop, q_valid, "window popped from empty queue")
  `ASSERT_IMPLIES(a_pop_idle, q_pop, !m_tvalid, "window popped while result pending")

endmodule

// ----- sv/wmdr_front.sv -----
// Front end: accepts samples, accumulates the window and closes it.
module wmdr_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [63:0]                            s_tdata,   // sample_value, timestamp_ms
  input  logic                                   s_tuser,   // sample_finite
  input  logic [wmdr_pkg::TS_W-1:0]              interval,
  input  logic                                   q_full,
  output logic                                   push,
  output logic [wmdr_pkg::SUM_W+COUNT_BITS-1:0]  push_data
);

  logic [wmdr_pkg::SUM_W-1:0] running_sum;
  logic [COUNT_BITS-1:0]      sample_count;
  logic [wmdr_pkg::TS_W-1:0]  window_start_ms;

  logic                        accept;
  logic [wmdr_pkg::VAL_W-1:0]  sample;
  logic [wmdr_pkg::TS_W-1:0]   ts;
  logic                        count_full;
  logic [wmdr_pkg::SUM_W:0]    sum_wide;
  logic [wmdr_pkg::SUM_W-1:0]  sum_sat;
  logic [wmdr_pkg::SUM_W-1:0]  sum_next;
  logic [COUNT_BITS-1:0]       count_next;
  logic [wmdr_pkg::TS_W-1:0]   elapsed;
  logic                        close;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready && s_tuser;
  assign sample   = s_tdata[31:0];
  assign ts       = s_tdata[63:32];

  assign count_full = (sample_count == {COUNT_BITS{1'b1}});
  assign sum_wide   = {running_sum[wmdr_pkg::SUM_W-1], running_sum}
                    + {{(wmdr_pkg::SUM_W-wmdr_pkg::VAL_W+1){sample[wmdr_pkg::VAL_W-1]}}, sample};

  always_comb begin
    if (sum_wide[wmdr_pkg::SUM_W] != sum_wide[wmdr_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[wmdr_pkg::SUM_W] ? wmdr_pkg::SUM_MIN : wmdr_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[wmdr_pkg::SUM_W-1:0];
    end
  end

  assign sum_next   = count_full ? running_sum : sum_sat;
  assign count_next = count_full ? sample_count : sample_count + 1'b1;
  assign elapsed    = ts - window_start_ms;
  assign close      = elapsed > interval;

  assign push      = accept && close;
  assign push_data = {count_next, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      sample_count    <= '0;
      window_start_ms <= '0;
    end else if (accept) begin
      if (close) begin
        running_sum     <= '0;
        sample_count    <= '0;
        window_start_ms <= ts;
      end else begin
        running_sum  <= sum_next;
        sample_count <= count_next;
      end
    end
  end

endmodule

// ----- sv/wmdr_queue.sv -----
// Two-entry queue of closed windows between front and back.
module wmdr_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic             full,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0]                  entries [wmdr_pkg::Q_DEPTH];
  logic [wmdr_pkg::QPTR_W-1:0]       wr_ptr;
  logic [wmdr_pkg::QPTR_W-1:0]       rd_ptr;
  logic [wmdr_pkg::QCNT_W-1:0]       fill;

  assign valid = (fill != '0);
  assign full  = (fill == wmdr_pkg::QCNT_W'(wmdr_pkg::Q_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- sv/wmdr_back.sv -----
// Back end: serial divide, clamp, deadband check and result register.
module wmdr_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  logic [wmdr_pkg::SUM_W+COUNT_BITS-1:0]  q_head,
  output logic                                   q_pop,
  input  logic [wmdr_pkg::DB_W-1:0]              deadband,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [47:0]                            m_tdata    // mean_value, samples_averaged
);

  wmdr_pkg::back_state_t state, state_next;

  logic [wmdr_pkg::STEP_W-1:0]  step;
  logic [wmdr_pkg::SUM_W-1:0]   quot;
  logic [COUNT_BITS-1:0]        remainder;
  logic [COUNT_BITS-1:0]        divisor;
  logic                         neg;
  logic [wmdr_pkg::VAL_W-1:0]   mean;
  logic [wmdr_pkg::VAL_W-1:0]   last_reported;
  logic [wmdr_pkg::VAL_W-1:0]   out_mean;
  logic [wmdr_pkg::OUT_CNT_W-1:0] out_count;

  logic [wmdr_pkg::SUM_W-1:0]   head_sum;
  logic [COUNT_BITS-1:0]        head_count;
  logic [wmdr_pkg::SUM_W-1:0]   head_mag;
  logic [COUNT_BITS:0]          trial;
  logic                         fits;
  logic                         last_step;
  logic [wmdr_pkg::VAL_W-1:0]   mean_fix;
  logic [wmdr_pkg::VAL_W:0]     diff;
  logic [wmdr_pkg::VAL_W:0]     diff_mag;
  logic                         report;

  assign head_sum   = q_head[wmdr_pkg::SUM_W-1:0];
  assign head_count = q_head[wmdr_pkg::SUM_W+COUNT_BITS-1:wmdr_pkg::SUM_W];
  assign head_mag   = head_sum[wmdr_pkg::SUM_W-1] ? -head_sum : head_sum;

  assign trial     = {remainder, quot[wmdr_pkg::SUM_W-1]};
  assign fits      = (trial >= {1'b0, divisor});
  assign last_step = (step == wmdr_pkg::STEP_W'(wmdr_pkg::SUM_W - 1));

  always_comb begin
    if (neg) begin
      if (quot > wmdr_pkg::SUM_W'({1'b1, {(wmdr_pkg::VAL_W-1){1'b0}}})) begin
        mean_fix = wmdr_pkg::MEAN_MIN;
      end else begin
        mean_fix = -quot[wmdr_pkg::VAL_W-1:0];
      end
    end else begin
      if (quot > wmdr_pkg::SUM_W'(wmdr_pkg::MEAN_MAX)) begin
        mean_fix = wmdr_pkg::MEAN_MAX;
      end else begin
        mean_fix = quot[wmdr_pkg::VAL_W-1:0];
      end
    end
  end

  assign diff     = {mean[wmdr_pkg::VAL_W-1], mean}
                  - {last_reported[wmdr_pkg::VAL_W-1], last_reported};
  assign diff_mag = diff[wmdr_pkg::VAL_W] ? -diff : diff;
  assign report   = (deadband == '0)
                  || (diff_mag >= {2'b00, deadband});

  always_comb begin
    state_next = state;
    unique case (state)
      wmdr_pkg::BK_IDLE: if (q_valid) state_next = wmdr_pkg::BK_DIV;
      wmdr_pkg::BK_DIV:  if (last_step) state_next = wmdr_pkg::BK_FIX;
      wmdr_pkg::BK_FIX:  state_next = wmdr_pkg::BK_CMP;
      wmdr_pkg::BK_CMP:  state_next = report ? wmdr_pkg::BK_OUT : wmdr_pkg::BK_IDLE;
      wmdr_pkg::BK_OUT:  if (m_tready) state_next = wmdr_pkg::BK_IDLE;
      default:           state_next = wmdr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      wmdr_pkg::BK_IDLE: q_pop = q_valid;
      wmdr_pkg::BK_OUT:  m_tvalid = 1'b1;
      default: begin
        q_pop    = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
  end

  assign m_tdata = {out_count, out_mean};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wmdr_pkg::BK_IDLE;
      last_reported <= '0;
    end else begin
      state <= state_next;
      if (state == wmdr_pkg::BK_CMP && report) begin
        last_reported <= mean;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wmdr_pkg::BK_IDLE: begin
        step      <= '0;
        quot      <= head_mag;
        remainder <= '0;
        divisor   <= head_count;
        neg       <= head_sum[wmdr_pkg::SUM_W-1];
      end
      wmdr_pkg::BK_DIV: begin
        step      <= step + 1'b1;
        quot      <= {quot[wmdr_pkg::SUM_W-2:0], fits};
        remainder <= fits ? COUNT_BITS'(trial - {1'b0, divisor}) : trial[COUNT_BITS-1:0];
      end
      wmdr_pkg::BK_FIX: begin
        mean <= mean_fix;
      end
      wmdr_pkg::BK_CMP: begin
        out_mean  <= mean;
        out_count <= wmdr_pkg::OUT_CNT_W'(divisor);
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule

// ----- tb/sv/windowed_mean_deadband_reporter_test.sv -----
// Self-checking testbench for the windowed mean deadband reporter.
`timescale 1ns / 100ps

module windowed_mean_deadband_reporter_test;
  import wmdr_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam int unsigned COUNT_FULL = (1 << COUNT_BITS) - 1;
  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 265;
  localparam int BURST_ITEMS = 40;

  typedef struct packed {
    logic [VAL_W-1:0]     mean;
    logic [OUT_CNT_W-1:0] count;
  } window_report_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    logic                 finite;
    logic [TS_W-1:0]      ts;
    logic                 pinned;
    logic [VAL_W-1:0]     pin_mean;
    logic [OUT_CNT_W-1:0] pin_count;
  } script_row_t;

  localparam int DIRECTED_ROWS = 27;
  localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h7FFFFFFF, 1'b1, 32'h00000000, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h7FFFFFFF, 1'b1, 32'h000001F4, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h80000000, 1'b0, 32'h00001388, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h7FFFFFFF, 1'b1, 32'h000003E9,
      1'b1, 32'h7FFFFFFF, 16'd3},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h80000000, 1'b1, 32'h000003E9, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h80000000, 1'b1, 32'h000007D2,
      1'b1, 32'h80000000, 16'd2},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'hFFFFFFFF, 1'b1, 32'h00000BBA, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000001, 1'b1, 32'h00000BBB,
      1'b1, 32'h00000000, 16'd2},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'hFFFFFFFD, 1'b1, 32'h00000BBB, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000000, 1'b1, 32'h00000FA4,
      1'b1, 32'hFFFFFFFF, 16'd2},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000005, 1'b1, 32'hFFFFFF00,
      1'b1, 32'h00000005, 16'd1},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000007, 1'b1, 32'h00000100, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000009, 1'b1, 32'h000002E9,
      1'b1, 32'h00000008, 16'd2},
    '{ROW_WRITE, REG_REPORT_DEADBAND, 32'h00008000, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0},
    '{ROW_WRITE, REG_WINDOW_INTERVAL, 32'h0000000A, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00004008, 1'b1, 32'h00000320, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00008008, 1'b1, 32'h00000384, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000008, 1'b1, 32'h000003E8, 1'b0, 32'h0, 16'h0},
    '{ROW_WRITE, REG_REPORT_DEADBAND, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h80000000, 1'b1, 32'h000007D0,
      1'b1, 32'h80000000, 16'd1},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h7FFFFFFF, 1'b1, 32'h00000BB8,
      1'b1, 32'h7FFFFFFF, 16'd1},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000000, 1'b1, 32'h00000FA0,
      1'b1, 32'h00000000, 16'd1},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'h00000001, 1'b1, 32'h00001388, 1'b0, 32'h0, 16'h0},
    '{ROW_WRITE, REG_WINDOW_INTERVAL, 32'h00000000, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'hFFFFFFFF, 1'b1, 32'h00001388, 1'b0, 32'h0, 16'h0},
    '{ROW_WRITE, REG_REPORT_DEADBAND, 32'h00000000, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0},
    '{ROW_SAMPLE, REG_WINDOW_INTERVAL, 32'hFFFFFFFF, 1'b1, 32'h00001389,
      1'b1, 32'hFFFFFFFF, 16'd2}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // sample_value, timestamp_ms
  logic                 s_tuser = 1'b0; // sample_finite
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;        // mean_value, samples_averaged
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state and register copies
  logic [TS_W-1:0]      cfg_interval = INTERVAL_RESET;
  logic [DB_W-1:0]      cfg_deadband = DEADBAND_RESET;
  int unsigned          acc_count = 0;
  longint               acc_sum = 0;
  logic [TS_W-1:0]      window_open_ms = '0;
  logic [VAL_W-1:0]     last_mean = '0;

  window_report_t       reports_due [$];
  int unsigned          mismatches = 0;
  int unsigned          stalled_cycles = 0;
  bit                   tx_eager = 1'b0;
  bit                   rx_eager = 1'b0;
  int unsigned          hold_requests = 0;
  int unsigned          holds_served = 0;
  int                   rx_hold_left = 0;
  int                   rx_gap_left = 0;

  windowed_mean_deadband_reporter #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 80);
    end
  endfunction

  function automatic bit fold_sample(input logic [VAL_W-1:0] value, input logic finite,
                                     input logic [TS_W-1:0] ts, output window_report_t rpt);
    longint sum;
    longint mean;
    longint gap;
    logic [TS_W-1:0] elapsed;
    rpt = '0;
    if (!finite) begin
      return 1'b0;
    end
    if (acc_count < COUNT_FULL) begin
      sum = acc_sum + longint'($signed(value));
      if (sum > SUM_HI) sum = SUM_HI;
      if (sum < SUM_LO) sum = SUM_LO;
      acc_sum = sum;
      acc_count++;
    end
    elapsed = ts - window_open_ms;
    if (elapsed <= cfg_interval) begin
      return 1'b0;
    end
    window_open_ms = ts;
    mean = (acc_count != 0) ? acc_sum / longint'(acc_count) : acc_sum;
    if (mean > longint'(32'sh7FFFFFFF)) mean = longint'(32'sh7FFFFFFF);
    if (mean < -longint'(64'sh80000000)) mean = -longint'(64'sh80000000);
    rpt.mean = mean[VAL_W-1:0];
    rpt.count = acc_count[OUT_CNT_W-1:0];
    acc_count = 0;
    acc_sum = 0;
    gap = mean - longint'($signed(last_mean));
    if (gap < 0) gap = -gap;
    if (cfg_deadband != '0 && gap < longint'(cfg_deadband)) begin
      return 1'b0;
    end
    last_mean = mean[VAL_W-1:0];
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [47:0] want,
                               input logic [47:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // enter and leave at a falling edge
  task automatic offer_sample(input logic [VAL_W-1:0] value, input logic finite,
                              input logic [TS_W-1:0] ts, input bit pinned,
                              input window_report_t pin);
    window_report_t rpt;
    bit fires;
    int gap;
    gap = tx_eager ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ts, value};
    s_tuser <= finite;
    do @(posedge clk); while (!s_tready);
    fires = fold_sample(value, finite, ts, rpt);
    if (pinned) begin
      reports_due.push_back(pin);
    end else if (fires) begin
      reports_due.push_back(rpt);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      REG_WINDOW_INTERVAL: cfg_interval = data;
      REG_REPORT_DEADBAND: cfg_deadband = data[DB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      rx_hold_left = RX_HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!rx_eager && $urandom_range(0, 3) == 0) rx_gap_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_reports
    window_report_t want;
    window_report_t got;
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= WATCHDOG_CYCLES) begin
      $display("windowed_mean_deadband_reporter: mismatch");
      $finish;
    end else if (!rst && m_tvalid && m_tready) begin
      got.mean = m_tdata[31:0];
      got.count = m_tdata[47:32];
      if (reports_due.size() == 0) begin
        note_mismatch("report with none pending", '0, m_tdata);
      end else begin
        want = reports_due.pop_front();
        if (got.mean !== want.mean) begin
          note_mismatch("mean_value", 48'(want.mean), 48'(got.mean));
        end
        if (got.count !== want.count) begin
          note_mismatch("samples_averaged", 48'(want.count), 48'(got.count));
        end
      end
    end
  end

  initial begin : stimulus
    script_row_t row;
    logic [TS_W-1:0] cur_ts;
    logic [VAL_W-1:0] value;
    logic [TS_W-1:0] ivl;
    logic [CFG_W-1:0] db;
    int r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.index, row.data);
      end else begin
        offer_sample(row.data, row.finite, row.ts, row.pinned, {row.pin_mean, row.pin_count});
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin ivl = 32'd1000; db = 32'h0; end
        1: begin ivl = 32'd0; db = 32'h0; end
        2: begin ivl = 32'd1; db = 32'h1; end
        3: begin ivl = 32'd37; db = 32'h4000; end
        4: begin ivl = 32'd5000; db = 32'h10000; end
        default: begin
          ivl = $urandom_range(2, 3000);
          db = $urandom_range(0, 32'h30000);
        end
      endcase
      write_reg(REG_WINDOW_INTERVAL, ivl);
      write_reg(REG_REPORT_DEADBAND, db);
      tx_eager = (phase == 3);
      rx_eager = (phase == 4);
      cur_ts = (phase == 4) ? 32'hFFFFE000 : window_open_ms;
      if (phase == 1) begin
        // hold the output while closing windows back to back
        tx_eager = 1'b1;
        hold_requests++;
        for (int i = 0; i < BURST_ITEMS; i++) begin
          cur_ts++;
          offer_sample($urandom(), 1'b1, cur_ts, 1'b0, '0);
        end
        tx_eager = 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          case ($urandom_range(0, 3))
            0: value = 32'h7FFFFFFF;
            1: value = 32'h80000000;
            2: value = 32'h0;
            default: value = 32'hFFFFFFFF;
          endcase
        end else if (r < 45) begin
          value = $urandom();
        end else begin
          value = $urandom_range(0, 32'h3FFFF) - 32'h20000;
        end
        if ($urandom_range(0, 49) == 0) begin
          cur_ts = $urandom();
        end else if ($urandom_range(0, 5) == 0) begin
          cur_ts = cur_ts + ivl + 1 + $urandom_range(0, 3);
        end else begin
          cur_ts = cur_ts + $urandom_range(0, ivl / 3 + 1);
        end
        offer_sample(value, $urandom_range(0, 9) != 0, cur_ts, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("windowed_mean_deadband_reporter: match");
    end else begin
      $display("windowed_mean_deadband_reporter: mismatch");
    end
    $finish;
  end

endmodule

// ----- windowed_mean_deadband_reporter.f -----
+incdir+sv
sv/wmdr_pkg.sv
sv/wmdr_front.sv
sv/wmdr_queue.sv
sv/wmdr_back.sv
sv/windowed_mean_deadband_reporter.sv
tb/sv/windowed_mean_deadband_reporter_test.sv
